// File: src/itoc_pkg.sv
// shared types, constants and the cordic arctangent table for the tilt block
package itoc_pkg;

    localparam int CAL_SAMPLES_DEF  = 100;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int IN_W   = 96;
    localparam int OUT_W  = 144;
    localparam int CNT_W  = 5;
    localparam int DIV_STEPS  = 3;
    localparam int SQRT_STEPS = 16;

    localparam logic [2:0] AXIS_LAST = 3'd5;
    localparam logic [2:0] AXIS_Z    = 3'd2;
    localparam logic [2:0] AXIS_GYRO = 3'd3;

    localparam logic signed [20:0] ONE_G_FRAC  = 21'sd262144;
    localparam logic [15:0]        ANGLE_LIMIT = 16'd11520;

    typedef enum logic [1:0] {
        DIV_ACCEL,
        DIV_GYRO,
        DIV_OFFS
    } div_sel_t;

    typedef struct packed {
        logic             load;
        logic             div_mul;
        logic             div_prep;
        logic             div_step;
        logic             div_wr;
        div_sel_t         div_sel;
        logic [2:0]       axis;
        logic             cor_start;
        logic             cor_sel;
        logic             cor_step;
        logic             cor_wr;
        logic             sq_ld0;
        logic             sq_ld1;
        logic             sq_step;
        logic             sq_wr;
        logic             out_load;
        logic             cal_upd;
        logic             off_done;
        logic [CNT_W-1:0] idx;
    } itoc_cmd_t;

    typedef struct packed {
        logic run_end;
    } itoc_stat_t;

    // arctangent of 2^-i in 2^-16 degree
    function automatic logic [21:0] atan_tab(input logic [CNT_W-1:0] i);
        logic [21:0] v;
        unique case (i)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// File: src/itoc_ctrl.sv
// sequencer for the tilt block: steps the shared divider, cordic and square root units
module itoc_ctrl #(
    parameter int CORDIC_STEPS = itoc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output itoc_pkg::itoc_cmd_t    cmd,
    input  itoc_pkg::itoc_stat_t   stat
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL,
        S_PREP,
        S_DIV,
        S_DWR,
        S_CSTART,
        S_CRUN,
        S_CWR,
        S_SQ0,
        S_SQ1,
        S_SQRUN,
        S_SQWR,
        S_OUT,
        S_CAL,
        S_ODONE
    } state_t;

    localparam logic [itoc_pkg::CNT_W-1:0] DIV_LAST =
        itoc_pkg::CNT_W'(itoc_pkg::DIV_STEPS - 1);
    localparam logic [itoc_pkg::CNT_W-1:0] COR_LAST = itoc_pkg::CNT_W'(CORDIC_STEPS - 1);
    localparam logic [itoc_pkg::CNT_W-1:0] SQ_LAST =
        itoc_pkg::CNT_W'(itoc_pkg::SQRT_STEPS - 1);

    state_t                      state_reg, state_next;
    logic [itoc_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [2:0]                  ax_reg, ax_next;
    logic                        off_reg, off_next;
    logic                        m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.idx     = cnt_reg;
        cmd.axis    = ax_reg;
        cmd.cor_sel = ax_reg[0];
        if (off_reg)
            cmd.div_sel = itoc_pkg::DIV_OFFS;
        else if (ax_reg < itoc_pkg::AXIS_GYRO)
            cmd.div_sel = itoc_pkg::DIV_ACCEL;
        else
            cmd.div_sel = itoc_pkg::DIV_GYRO;

        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ax_next       = ax_reg;
        off_next      = off_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    ax_next    = 3'd0;
                    off_next   = 1'b0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.div_mul = 1'b1;
                state_next  = S_PREP;
            end
            S_PREP:
            begin
                cmd.div_prep = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_DWR;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_DWR:
            begin
                cmd.div_wr = 1'b1;
                if (ax_reg == itoc_pkg::AXIS_LAST)
                begin
                    ax_next    = 3'd0;
                    state_next = off_reg ? S_ODONE : S_CSTART;
                end
                else
                begin
                    ax_next    = ax_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_CSTART:
            begin
                cmd.cor_start = 1'b1;
                cnt_next      = '0;
                state_next    = S_CRUN;
            end
            S_CRUN:
            begin
                cmd.cor_step = 1'b1;
                if (cnt_reg == COR_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_CWR;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_CWR:
            begin
                cmd.cor_wr = 1'b1;
                if (ax_reg[0])
                    state_next = S_SQ0;
                else
                begin
                    ax_next    = 3'd1;
                    state_next = S_CSTART;
                end
            end
            S_SQ0:
            begin
                cmd.sq_ld0 = 1'b1;
                state_next = S_SQ1;
            end
            S_SQ1:
            begin
                cmd.sq_ld1 = 1'b1;
                cnt_next   = '0;
                state_next = S_SQRUN;
            end
            S_SQRUN:
            begin
                cmd.sq_step = 1'b1;
                if (cnt_reg == SQ_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_SQWR;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_SQWR:
            begin
                cmd.sq_wr  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // wait until the output word has been taken
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_CAL;
                end
            end
            S_CAL:
            begin
                cmd.cal_upd = 1'b1;
                if (stat.run_end)
                begin
                    off_next   = 1'b1;
                    ax_next    = 3'd0;
                    state_next = S_MUL;
                end
                else
                    state_next = S_IDLE;
            end
            S_ODONE:
            begin
                cmd.off_done = 1'b1;
                off_next     = 1'b0;
                state_next   = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            ax_reg       <= '0;
            off_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            ax_reg       <= ax_next;
            off_reg      <= off_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// File: src/itoc_dp.sv
// datapath: offsets, calibration sums, reciprocal divider, cordic and square root
module itoc_dp #(
    parameter int CAL_SAMPLES = itoc_pkg::CAL_SAMPLES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  itoc_pkg::itoc_cmd_t          cmd,
    output itoc_pkg::itoc_stat_t         stat,
    input  logic                         in_kind,
    input  logic [itoc_pkg::IN_W-1:0]    in_data,
    output logic [itoc_pkg::OUT_W-1:0]   out_data,
    output logic                         out_user
);

    localparam int CNT_SW = $clog2(CAL_SAMPLES + 1);

    // reciprocals rounded up and scaled by 2^30; 51200 is a shift by 11 and then 25
    localparam int          ACC_SHIFT  = 11;
    localparam int          ACC_DEN    = 25;
    localparam int          GYRO_DEN   = 131;
    localparam logic [30:0] RECIP_ACC  = 31'((2**30 + ACC_DEN - 1) / ACC_DEN);
    localparam logic [30:0] RECIP_GYRO = 31'((2**30 + GYRO_DEN - 1) / GYRO_DEN);
    localparam logic [30:0] RECIP_OFFS = 31'((2**30 + CAL_SAMPLES - 1) / CAL_SAMPLES);
    localparam logic [itoc_pkg::CNT_W-1:0] STEP_HI  = itoc_pkg::CNT_W'(0);
    localparam logic [itoc_pkg::CNT_W-1:0] STEP_REM = itoc_pkg::CNT_W'(1);

    logic signed [15:0] raw_reg  [6];
    logic signed [23:0] sums_reg [6];
    logic signed [20:0] offs_reg [6];
    logic               kind_reg;
    logic               valid_reg;
    logic [CNT_SW-1:0]  count_reg;

    logic signed [21:0] corr [6];

    // divider
    logic signed [31:0] prod_reg, prod_next;
    logic [31:0]        mag_reg;
    logic               neg_reg;
    logic [15:0]        den;
    logic [8:0]         den_lo;
    logic [30:0]        recip;
    logic [3:0]         pre_sh;
    logic [13:0]        qh_reg, ql_reg;
    logic [21:0]        rx_reg;
    logic [44:0]        hi_prod;
    logic [22:0]        qd;
    logic [13:0]        rh;
    logic [52:0]        lo_prod;
    logic [32:0]        qmag;
    logic signed [32:0] qs;
    logic signed [15:0] q_sat;
    logic [1:0]         rate_idx;

    // cordic
    logic signed [40:0] x_reg, y_reg;
    logic signed [25:0] z_reg;
    logic               zero_reg;
    logic signed [21:0] cy, cx;
    logic signed [40:0] cy_w, cx_w, dx, dy;
    logic signed [25:0] at;
    logic [25:0]        zmag;
    logic [15:0]        zrnd;
    logic [14:0]        amag;
    logic signed [14:0] angle;

    // square root
    logic signed [14:0] pitch_reg, roll_reg;
    logic [14:0]        tilt_reg;
    logic [31:0]        n_reg, r_reg, bit_reg, trial;
    logic signed [15:0] acc_reg  [3];
    logic signed [15:0] rate_reg [3];

    logic [itoc_pkg::OUT_W-1:0] out_data_reg;
    logic                       out_user_reg;
    logic                       run_end;

    assign out_data = out_data_reg;
    assign out_user = out_user_reg;
    assign run_end  = kind_reg &&
        (({1'b0, count_reg} + 1'b1) >= (CNT_SW + 1)'(CAL_SAMPLES));
    assign stat.run_end = run_end;

    always_comb
    begin
        for (int k = 0; k < 6; k++)
            corr[k] = {{2{raw_reg[k][15]}}, raw_reg[k], 4'b0000} -
                      (valid_reg ? {offs_reg[k][20], offs_reg[k]} : 22'sd0);
    end

    always_comb
    begin
        unique case (cmd.div_sel)
            itoc_pkg::DIV_ACCEL:
            begin
                prod_next = 32'(corr[cmd.axis]) * 32'sd981;
                den       = 16'd51200;
                den_lo    = 9'(ACC_DEN);
                recip     = RECIP_ACC;
                pre_sh    = 4'(ACC_SHIFT);
            end
            itoc_pkg::DIV_GYRO:
            begin
                prod_next = 32'(corr[cmd.axis]) <<< 1;
                den       = 16'd131;
                den_lo    = 9'(GYRO_DEN);
                recip     = RECIP_GYRO;
                pre_sh    = 4'd0;
            end
            itoc_pkg::DIV_OFFS:
            begin
                prod_next = 32'(sums_reg[cmd.axis]) <<< 4;
                den       = 16'(CAL_SAMPLES);
                den_lo    = 9'(CAL_SAMPLES);
                recip     = RECIP_OFFS;
                pre_sh    = 4'd0;
            end
            default:
            begin
                prod_next = '0;
                den       = 16'd1;
                den_lo    = 9'd1;
                recip     = 31'(2**30);
                pre_sh    = 4'd0;
            end
        endcase
    end

    // quotient as two base 2^14 digits, each from one reciprocal product
    assign hi_prod  = 45'(mag_reg[27:14]) * 45'(recip);
    assign qd       = 23'(qh_reg) * 23'(den_lo);
    assign rh       = mag_reg[27:14] - qd[13:0];
    assign lo_prod  = 53'(rx_reg) * 53'(recip);
    assign qmag     = {5'd0, qh_reg, ql_reg};
    assign qs       = neg_reg ? -$signed(qmag) : $signed(qmag);
    assign rate_idx = 2'(cmd.axis - itoc_pkg::AXIS_GYRO);

    always_comb
    begin
        if (qs > 33'sd32767)
            q_sat = 16'sd32767;
        else if (qs < -33'sd32768)
            q_sat = -16'sd32768;
        else
            q_sat = qs[15:0];
    end

    // cordic operands and step
    assign cy   = cmd.cor_sel ? corr[1] : corr[0];
    assign cx   = corr[2];
    assign cy_w = {{3{cy[21]}}, cy, 16'd0};
    assign cx_w = {{3{cx[21]}}, cx, 16'd0};
    assign dx   = y_reg >>> cmd.idx;
    assign dy   = x_reg >>> cmd.idx;
    assign at   = {4'd0, itoc_pkg::atan_tab(cmd.idx)};

    // round to 1/64 degree, ties away from zero, then clamp
    assign zmag = z_reg[25] ? 26'(-z_reg) : 26'(z_reg);
    assign zrnd = 16'((zmag + 26'd512) >> 10);
    assign amag = (zrnd > itoc_pkg::ANGLE_LIMIT) ? 15'(itoc_pkg::ANGLE_LIMIT) : zrnd[14:0];
    assign angle = zero_reg ? 15'sd0 : (z_reg[25] ? -$signed(amag) : $signed(amag));

    assign trial = r_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= 1'b0;
            valid_reg <= 1'b0;
            count_reg <= '0;
            for (int k = 0; k < 6; k++)
            begin
                sums_reg[k] <= '0;
                offs_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                kind_reg <= in_kind;
                // first calibration word of a run
                if (in_kind && count_reg == '0)
                begin
                    valid_reg <= 1'b0;
                    for (int k = 0; k < 6; k++)
                        sums_reg[k] <= '0;
                end
            end
            if (cmd.cal_upd && kind_reg)
            begin
                for (int k = 0; k < 6; k++)
                    sums_reg[k] <= sums_reg[k] + 24'(raw_reg[k]);
                count_reg <= run_end ? '0 : count_reg + 1'b1;
            end
            if (cmd.div_wr && cmd.div_sel == itoc_pkg::DIV_OFFS)
            begin
                if (cmd.axis == itoc_pkg::AXIS_Z)
                    offs_reg[cmd.axis] <= qs[20:0] - itoc_pkg::ONE_G_FRAC;
                else
                    offs_reg[cmd.axis] <= qs[20:0];
            end
            if (cmd.off_done)
                valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int k = 0; k < 6; k++)
                raw_reg[k] <= in_data[16*k +: 16];
        end

        if (cmd.div_mul)
            prod_reg <= prod_next;
        if (cmd.div_prep)
        begin
            neg_reg <= prod_reg[31];
            mag_reg <= ((prod_reg[31] ? 32'(-prod_reg) : 32'(prod_reg)) + {17'd0, den[15:1]})
                       >> pre_sh;
        end
        if (cmd.div_step)
        begin
            if (cmd.idx == STEP_HI)
                qh_reg <= hi_prod[43:30];
            else if (cmd.idx == STEP_REM)
                rx_reg <= {rh[7:0], mag_reg[13:0]};
            else
                ql_reg <= lo_prod[43:30];
        end
        if (cmd.div_wr)
        begin
            if (cmd.div_sel == itoc_pkg::DIV_ACCEL)
                acc_reg[cmd.axis[1:0]] <= q_sat;
            else if (cmd.div_sel == itoc_pkg::DIV_GYRO)
                rate_reg[rate_idx] <= q_sat;
        end

        if (cmd.cor_start)
        begin
            zero_reg <= (cx == 22'sd0) && (cy == 22'sd0);
            if (cx < 0)
            begin
                x_reg <= -cx_w;
                y_reg <= -cy_w;
                z_reg <= (cy >= 0) ? 26'sd11796480 : -26'sd11796480;
            end
            else
            begin
                x_reg <= cx_w;
                y_reg <= cy_w;
                z_reg <= '0;
            end
        end
        if (cmd.cor_step)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
        end
        if (cmd.cor_wr)
        begin
            if (cmd.cor_sel)
                roll_reg <= angle;
            else
                pitch_reg <= angle;
        end

        if (cmd.sq_ld0)
            n_reg <= 32'(pitch_reg * pitch_reg);
        if (cmd.sq_ld1)
        begin
            n_reg   <= n_reg + 32'(roll_reg * roll_reg);
            r_reg   <= '0;
            bit_reg <= 32'd1 << 30;
        end
        if (cmd.sq_step)
        begin
            if (n_reg >= trial)
            begin
                n_reg <= n_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
                r_reg <= r_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
        // remainder above root means the nearer integer is one up
        if (cmd.sq_wr)
            tilt_reg <= (n_reg > r_reg) ? 15'(r_reg + 32'd1) : r_reg[14:0];

        if (cmd.out_load)
        begin
            out_data_reg <= {3'b000, tilt_reg, roll_reg, pitch_reg,
                             rate_reg[2], rate_reg[1], rate_reg[0],
                             acc_reg[2], acc_reg[1], acc_reg[0]};
            out_user_reg <= valid_reg;
        end
    end

endmodule

// File: src/imu_tilt_and_offset_calibration.sv
// one word at a time: the next input word is taken once the last one is fully worked on
// six scaled quotients, two cordic passes and a 16-step square root make up the work
// a calibration word that completes a run adds six offset quotients
// a result word waits in the output register while the next input word is worked on
// rst_n is asynchronous: clears the sums, offsets, sample count and calibrated flag
module imu_tilt_and_offset_calibration #(
    parameter int CAL_SAMPLES  = itoc_pkg::CAL_SAMPLES_DEF,
    parameter int CORDIC_STEPS = itoc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // raw_accel_x, raw_accel_y, raw_accel_z, raw_gyro_x, raw_gyro_y, raw_gyro_z
    input  logic [itoc_pkg::IN_W-1:0]    s_tdata,
    // kind
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // accel_x_mps2, accel_y_mps2, accel_z_mps2, rate_x_dps, rate_y_dps, rate_z_dps,
    // pitch_deg, roll_deg, tilt_deg, zero pad
    output logic [itoc_pkg::OUT_W-1:0]   m_tdata,
    // is_calibrated
    output logic                         m_tuser
);

    itoc_pkg::itoc_cmd_t  cmd;
    itoc_pkg::itoc_stat_t stat;

    itoc_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    itoc_dp #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_kind  (s_tuser),
        .in_data  (s_tdata),
        .out_data (m_tdata),
        .out_user (m_tuser)
    );

endmodule
